// File: rtl/core/btgb_pkg.sv
// types, constants and codes shared by the bitmap text glyph blitter
package btgb_pkg;

  localparam int unsigned GlyphStoreDepth = 4096;
  localparam int unsigned MaxGlyphRows    = 32;
  localparam int unsigned GlyphPixels     = 8;
  localparam int unsigned StoreAw         = $clog2(GlyphStoreDepth);

  localparam logic [7:0] CharSpace = 8'h20;

  typedef enum logic [1:0] {
    FuncLoad  = 2'd0,
    FuncBegin = 2'd1,
    FuncDraw  = 2'd2
  } func_e;

  typedef enum logic [2:0] {
    CfgFontWidth    = 3'd0,
    CfgGlyphHeight  = 3'd1,
    CfgBufferWidth  = 3'd2,
    CfgBufferHeight = 3'd3,
    CfgScaleX       = 3'd4,
    CfgScaleY       = 3'd5,
    CfgFlipY        = 3'd6,
    CfgDrawColor    = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    StIdle,
    StSetup,
    StRows
  } state_e;

  typedef struct packed {
    logic [1:0]  func;
    logic [11:0] glyph_addr;
    logic [7:0]  glyph_byte;
    logic [11:0] start_x;
    logic [11:0] start_y;
    logic [7:0]  char_code;
  } in_item_t;

  typedef struct packed {
    logic [25:0] row_offset;
    logic [7:0]  pixel_mask;
    logic        outside;
    logic        last_row;
  } out_item_t;

endpackage

// File: rtl/core/bitmap_text_glyph_blitter_unit.sv
// text overlay engine: glyph memory, pen state and per-row mask generation
//
// Load and begin items are taken alone, as is a character that draws
// nothing (code 0, space, codes above 127, or glyph height 0). A drawn
// character is accepted, then the setup state forms the start offset with
// the pen y times buffer width product, then one glyph memory read per row
// (rows being glyph_height capped at 32) goes through the single read port.
// No new item is accepted until the last row of a character is issued. Rows
// come out in order, each through a memory read stage and an output register;
// a stalled output holds the row sequence without losing items. Glyph memory
// contents are undefined until loaded and need no clearing after reset.
module bitmap_text_glyph_blitter_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_idx_i,
  input  logic [23:0]          cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  btgb_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output btgb_pkg::out_item_t  out_data_o
);
  import btgb_pkg::*;

  // configuration
  logic [7:0]  font_width_q;
  logic [5:0]  glyph_height_q;
  logic [12:0] buffer_width_q;
  logic [12:0] buffer_height_q;
  logic        scale_x_q;
  logic        scale_y_q;
  logic        flip_y_q;

  // pen and control
  state_e             state_q, state_d;
  logic [20:0]        pen_x_q, pen_x_d;
  logic signed [20:0] pen_y_q, pen_y_d;

  // per-character context
  logic [20:0]        cx_q;
  logic [12:0]        base_addr_q;
  logic [5:0]         row_q;
  logic [5:0]         rows_q;
  logic signed [21:0] row_y_q;
  logic [25:0]        acc_q;
  logic               x_out_q;

  // read stage and output register
  logic        s1_valid_q;
  logic [25:0] s1_offset_q;
  logic        s1_outside_q;
  logic        s1_last_q;
  logic [7:0]  rd_q;
  logic        out_valid_q;
  out_item_t   out_q;

  logic [7:0] glyph_mem [GlyphStoreDepth];

  logic              accept;
  logic              out_free, s1_adv, s1_free, issue;
  logic              last;
  logic              printable;
  logic              draw_start;
  logic [StoreAw-1:0] rd_addr;
  logic [StoreAw-1:0] wr_addr;
  logic [16:0]       rd_addr_full;
  logic [16:0]       wr_addr_full;
  logic              row_outside;
  logic [21:0]       pen_x_adv;
  logic [19:0]       x_mul;
  logic [17:0]       y_mul;
  logic signed [21:0] y_sel;
  logic signed [21:0] y_flip;
  logic signed [34:0] y_prod;
  logic signed [35:0] pix_sum;
  logic [25:0]       pix_lo;
  logic [25:0]       acc_init;
  logic [25:0]       bw3;
  logic [5:0]        rows_cap;
  logic [21:0]       x_end;

  // handshake and sequencing
  always_comb begin
    out_free   = !out_valid_q || out_ready_i;
    s1_adv     = s1_valid_q && out_free;
    s1_free    = !s1_valid_q || s1_adv;
    in_ready_o = (state_q == StIdle);
    issue      = (state_q == StRows) && s1_free;
  end

  assign accept    = in_valid_i && in_ready_o;
  assign printable = (in_data_i.char_code != 8'd0) && !in_data_i.char_code[7] &&
                     (in_data_i.char_code != CharSpace);
  assign draw_start = accept && (func_e'(in_data_i.func) == FuncDraw) && printable &&
                      (glyph_height_q != 6'd0);
  assign last = (row_q == rows_q - 6'd1);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (draw_start) state_d = StSetup;
      StSetup: state_d = StRows;
      StRows:  if (issue && last) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // begin item arithmetic
  always_comb begin
    x_mul  = in_data_i.start_x * font_width_q;
    y_mul  = in_data_i.start_y * glyph_height_q;
    y_sel  = scale_y_q ? $signed({4'd0, y_mul}) : $signed({10'd0, in_data_i.start_y});
    y_flip = $signed({9'd0, buffer_height_q}) - y_sel - $signed({16'd0, glyph_height_q});
  end

  // pen update
  always_comb begin
    pen_x_d   = pen_x_q;
    pen_y_d   = pen_y_q;
    pen_x_adv = {1'b0, pen_x_q} + 22'(GlyphPixels);
    if (accept) begin
      unique case (in_data_i.func)
        FuncBegin: begin
          pen_x_d = scale_x_q ? {1'b0, x_mul} : {9'd0, in_data_i.start_x};
          pen_y_d = flip_y_q ? y_flip[20:0] : y_sel[20:0];
        end
        FuncDraw: begin
          pen_x_d = pen_x_adv[21] ? {21{1'b1}} : pen_x_adv[20:0];
        end
        default: ;
      endcase
    end
  end

  // start offset: 3 * (pen_x + pen_y * buffer_width), modulo 2^26
  always_comb begin
    y_prod   = pen_y_q * $signed({1'b0, buffer_width_q});
    pix_sum  = 36'(y_prod) + $signed({15'd0, cx_q});
    pix_lo   = pix_sum[25:0];
    acc_init = {pix_lo[24:0], 1'b0} + pix_lo;
    bw3      = 26'({buffer_width_q, 1'b0}) + 26'(buffer_width_q);
    rows_cap = (32'(glyph_height_q) > MaxGlyphRows) ? 6'(MaxGlyphRows) : glyph_height_q;
    x_end    = {1'b0, pen_x_q} + 22'(GlyphPixels);
  end

  assign row_outside = row_y_q[21] || (row_y_q >= $signed({9'd0, buffer_height_q})) || x_out_q;
  assign rd_addr_full = 17'(base_addr_q) + 17'(row_q);
  assign rd_addr      = rd_addr_full[StoreAw-1:0];
  assign wr_addr_full = 17'(in_data_i.glyph_addr);
  assign wr_addr      = wr_addr_full[StoreAw-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= StIdle;
      pen_x_q         <= '0;
      pen_y_q         <= '0;
      font_width_q    <= 8'd8;
      glyph_height_q  <= 6'd8;
      buffer_width_q  <= 13'd640;
      buffer_height_q <= 13'd480;
      scale_x_q       <= 1'b0;
      scale_y_q       <= 1'b0;
      flip_y_q        <= 1'b0;
      s1_valid_q      <= 1'b0;
      out_valid_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      pen_x_q <= pen_x_d;
      pen_y_q <= pen_y_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CfgFontWidth:    font_width_q    <= cfg_wdata_i[7:0];
          CfgGlyphHeight:  glyph_height_q  <= cfg_wdata_i[5:0];
          CfgBufferWidth:  buffer_width_q  <= cfg_wdata_i[12:0];
          CfgBufferHeight: buffer_height_q <= cfg_wdata_i[12:0];
          CfgScaleX:       scale_x_q       <= cfg_wdata_i[0];
          CfgScaleY:       scale_y_q       <= cfg_wdata_i[0];
          CfgFlipY:        flip_y_q        <= cfg_wdata_i[0];
          CfgDrawColor:    ; // paint color is used downstream only
          default:         ;
        endcase
      end
      if (issue) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // per-character context and row stepping
  always_ff @(posedge clk_i) begin
    if (draw_start) begin
      cx_q        <= pen_x_q;
      base_addr_q <= in_data_i.char_code[6:0] * glyph_height_q;
      rows_q      <= rows_cap;
      x_out_q     <= x_end > {9'd0, buffer_width_q};
      row_q       <= '0;
    end
    if (state_q == StSetup) begin
      acc_q   <= acc_init;
      row_y_q <= 22'(pen_y_q);
    end
    if (issue) begin
      s1_offset_q  <= row_outside ? 26'd0 : acc_q;
      s1_outside_q <= row_outside;
      s1_last_q    <= last;
      row_q        <= row_q + 6'd1;
      row_y_q      <= row_y_q + 22'sd1;
      acc_q        <= acc_q + bw3;
    end
    if (s1_adv) begin
      out_q.row_offset <= s1_offset_q;
      out_q.pixel_mask <= rd_q;
      out_q.outside    <= s1_outside_q;
      out_q.last_row   <= s1_last_q;
    end
  end

  // glyph memory
  always_ff @(posedge clk_i) begin
    if (accept && (func_e'(in_data_i.func) == FuncLoad)) begin
      glyph_mem[wr_addr] <= in_data_i.glyph_byte;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      rd_q <= glyph_mem[rd_addr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
